// File: hdl/vatr_pkg.sv
// Shared constants, types and arithmetic helpers for the vertex transform core.
`timescale 1ns / 1ps
package vatr_pkg;

	localparam int COEF_W         = 18;
	localparam int COEF_FRAC_BITS = 14;
	localparam int POS_FRAC_BITS  = 16;
	localparam int NORM_ONE_BITS  = 14;

	localparam int IN_W  = 144;
	localparam int OUT_W = 168;

	localparam int ROW_W = 3 * COEF_W;
	localparam int MAG_W = 36;
	localparam int A_W   = 31;

	// square root: two restoring steps per stage, 32 steps in all
	localparam int ISQ_STEPS  = 2;
	localparam int ISQ_STAGES = 32 / ISQ_STEPS;

	// divider: three quotient bits per stage
	localparam int DIV_BITS   = NORM_ONE_BITS + 1;
	localparam int DIV_STEPS  = 3;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
	localparam int REM_W      = A_W + NORM_ONE_BITS + 2;

	localparam logic [2:0] REG_ROW_X  = 3'd0;
	localparam logic [2:0] REG_ROW_Y  = 3'd1;
	localparam logic [2:0] REG_ROW_Z  = 3'd2;
	localparam logic [2:0] REG_OFF_X  = 3'd3;
	localparam logic [2:0] REG_OFF_Y  = 3'd4;
	localparam logic [2:0] REG_OFF_Z  = 3'd5;
	localparam logic [2:0] REG_SCALE  = 3'd6;
	localparam logic [2:0] REG_BONE   = 3'd7;

	typedef struct packed {
		logic        clip;
		logic [31:0] val;
	} sat_t;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic             clip;
		logic [15:0]      joint;
		logic             weight;
		logic [2:0]       neg;
		logic             zero;
	} side_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] root;
	} sq_t;

	typedef struct packed {
		sq_t                 sq;
		logic [2:0][A_W-1:0] a;
		side_t               side;
	} isq_t;

	typedef struct packed {
		logic [2:0][REM_W-1:0]    rem;
		logic [2:0][DIV_BITS-1:0] q;
		logic [31:0]              len;
		side_t                    side;
	} div_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		r.clip = 1'b0;
		r.val  = v[31:0];
		if (v > 64'sd2147483647) begin
			r.clip = 1'b1;
			r.val  = 32'h7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			r.clip = 1'b1;
			r.val  = 32'h8000_0000;
		end
		return r;
	endfunction

	// one restoring square-root step; idx 0 tests the highest bit pair
	function automatic sq_t isq_step(input sq_t x, input int unsigned idx);
		sq_t         r;
		logic [63:0] bitv;
		logic [63:0] t;
		bitv = 64'(1) << (62 - 2 * idx);
		t    = x.root + bitv;
		if (x.rem >= t) begin
			r.rem  = x.rem - t;
			r.root = (x.root >> 1) + bitv;
		end else begin
			r.rem  = x.rem;
			r.root = x.root >> 1;
		end
		return r;
	endfunction

endpackage

// File: hdl/vertex_affine_transform_renorm_core.sv
// Vertex transform core: scaled affine position transform and normal renormalization.
//
// Usage:
//   Vertices enter on the s_* stream (pos_x/y/z Q16.16, norm_x/y/z Q1.14) and leave
//   on the m_* stream with the transformed position, the unit normal, the joint
//   binding and a clip flag. Configuration (matrix rows, offsets, scale, bone) is
//   written over the APB-style port at byte address 8*i while no vertex is in flight;
//   the user must keep to this, as the block does not enforce it. Depth: 31 register
//   stages, most of them in the square-root pipe (16 stages of two steps) followed
//   by the divide pipe (5 stages of three quotient bits). Throughput: one vertex per
//   clock while no result waits at the output, as every stage then takes a new request.
//   Reset clears every valid bit and loads the identity matrix, zero offset,
//   unit scale and a static binding; s_tready is high as soon as reset ends.
//   When the receiver stalls with a result waiting, the whole pipe holds in place:
//   s_tready drops in the same cycle, nothing is lost or repeated, and bubbles
//   already in the pipe stay where they are.
`timescale 1ns / 1ps
module vertex_affine_transform_renorm_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
	input  logic [vatr_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
	// joint_index, weight_full, clipped, zero fill
	output logic [vatr_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [5:0]                  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);
	import vatr_pkg::*;

	// configuration registers
	logic [ROW_W-1:0] row_q [3];
	logic [31:0]      off_q [3];
	logic [31:0]      scale_q;
	logic [16:0]      bone_q;

	logic en;
	logic cfg_wr;

	// stage registers
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [64:0] sp_s1 [3];
	logic signed [33:0] np_s1 [3][3];
	logic signed [31:0] s_s2 [3];
	logic signed [35:0] r_s2 [3];
	logic               clip_s2, clip_s3, clip_s4;
	logic signed [49:0] lp_s3 [3][3];
	logic [MAG_W-1:0]   mag_s3 [3];
	logic [2:0]         neg_s3, neg_s4;
	logic signed [52:0] acc_s4 [3];
	logic [MAG_W-1:0]   mag_s4 [3];
	logic [MAG_W-1:0]   max_s4;
	logic [MAG_W-1:0]   mag_s5 [3];
	logic [2:0]         rsh_s5;
	logic [4:0]         lsh_s5;
	side_t              side_s5, side_s6, side_s7;
	logic [2:0][A_W-1:0] a_s6, a_s7;
	logic [61:0]        sq_s7 [3];

	isq_t               isq_s [ISQ_STAGES+1];
	logic [ISQ_STAGES:0] isq_v_s;
	div_t               dv_s [DIV_STAGES+1];
	logic [DIV_STAGES:0] dv_v_s;

	logic [OUT_W-1:0]   tdata_q;
	logic               tvalid_q;

	// combinational intermediates
	logic [31:0]        pos_in [3];
	logic [15:0]        norm_in [3];
	logic signed [17:0] coef_c [3][3];
	logic signed [31:0] s_c [3];
	logic               clip2_c;
	logic signed [35:0] r_c [3];
	logic [MAG_W-1:0]   mag_c [3];
	logic signed [52:0] acc_c [3];
	logic [MAG_W-1:0]   max_c;
	side_t              side_c;
	logic [5:0]         msb_c;
	logic [2:0]         rsh_c;
	logic [4:0]         lsh_c;
	logic [2:0][A_W-1:0] a_c;
	isq_t               isq_head_c;
	div_t               dv_head_c;
	logic [OUT_W-1:0]   out_c;

	// The whole pipe advances unless a result sits unaccepted at the output.
	assign en       = !tvalid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// ---------------- configuration port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW_W'(1) << COEF_FRAC_BITS;
			row_q[1] <= ROW_W'(1) << (COEF_FRAC_BITS + COEF_W);
			row_q[2] <= ROW_W'(1) << (COEF_FRAC_BITS + 2 * COEF_W);
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
			scale_q  <= 32'(1) << POS_FRAC_BITS;
			bone_q   <= '1;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_ROW_X: row_q[0] <= pwdata[ROW_W-1:0];
				REG_ROW_Y: row_q[1] <= pwdata[ROW_W-1:0];
				REG_ROW_Z: row_q[2] <= pwdata[ROW_W-1:0];
				REG_OFF_X: off_q[0] <= pwdata[31:0];
				REG_OFF_Y: off_q[1] <= pwdata[31:0];
				REG_OFF_Z: off_q[2] <= pwdata[31:0];
				REG_SCALE: scale_q  <= pwdata[31:0];
				REG_BONE:  bone_q   <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_ROW_X: prdata = 64'(row_q[0]);
			REG_ROW_Y: prdata = 64'(row_q[1]);
			REG_ROW_Z: prdata = 64'(row_q[2]);
			REG_OFF_X: prdata = 64'(off_q[0]);
			REG_OFF_Y: prdata = 64'(off_q[1]);
			REG_OFF_Z: prdata = 64'(off_q[2]);
			REG_SCALE: prdata = 64'(scale_q);
			REG_BONE:  prdata = 64'(bone_q);
			default:   prdata = '0;
		endcase
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			isq_v_s  <= '0;
			dv_v_s   <= '0;
			tvalid_q <= 1'b0;
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			isq_v_s  <= {isq_v_s[ISQ_STAGES-1:0], v_s7};
			dv_v_s   <= {dv_v_s[DIV_STAGES-1:0], isq_v_s[ISQ_STAGES]};
			tvalid_q <= dv_v_s[DIV_STAGES];
		end
	end

	// ---------------- stage 1: scale and normal products ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos_in[i]  = s_tdata[32*i +: 32];
			norm_in[i] = s_tdata[96 + 16*i +: 16];
			for (int k = 0; k < 3; k++) begin
				coef_c[i][k] = $signed(row_q[i][COEF_W*k +: COEF_W]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sp_s1[i] <= $signed(pos_in[i]) * $signed({1'b0, scale_q});
				for (int k = 0; k < 3; k++) begin
					np_s1[i][k] <= coef_c[i][k] * $signed(norm_in[k]);
				end
			end
		end
	end

	// ---------------- stage 2: round and saturate scaled position, sum normal ----------------
	always_comb begin
		logic signed [64:0] rnd;
		logic signed [64:0] sh;
		sat_t               st;
		clip2_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rnd     = sp_s1[i] + (65'sd1 <<< (POS_FRAC_BITS - 1));
			sh      = rnd >>> POS_FRAC_BITS;
			st      = sat32(64'(sh));
			s_c[i]  = $signed(st.val);
			clip2_c = clip2_c | st.clip;
			r_c[i]  = 36'(np_s1[i][0]) + 36'(np_s1[i][1]) + 36'(np_s1[i][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2    <= s_c;
			r_s2    <= r_c;
			clip_s2 <= clip2_c;
		end
	end

	// ---------------- stage 3: linear products, normal magnitudes ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = r_s2[i][35] ? MAG_W'(-r_s2[i]) : MAG_W'(r_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					lp_s3[i][k] <= coef_c[i][k] * s_s2[k];
				end
				neg_s3[i] <= r_s2[i][35];
			end
			mag_s3  <= mag_c;
			clip_s3 <= clip_s2;
		end
	end

	// ---------------- stage 4: sum with offset, largest normal magnitude ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = (53'($signed(off_q[i])) <<< COEF_FRAC_BITS)
				+ 53'(lp_s3[i][0]) + 53'(lp_s3[i][1]) + 53'(lp_s3[i][2]);
		end
		max_c = mag_s3[0];
		if (mag_s3[1] > max_c) begin
			max_c = mag_s3[1];
		end
		if (mag_s3[2] > max_c) begin
			max_c = mag_s3[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s4  <= acc_c;
			mag_s4  <= mag_s3;
			max_s4  <= max_c;
			neg_s4  <= neg_s3;
			clip_s4 <= clip_s3;
		end
	end

	// ---------------- stage 5: final position, binding, normalizing shift ----------------
	always_comb begin
		logic signed [52:0] rnd;
		logic signed [52:0] sh;
		sat_t               st;
		side_c.clip = clip_s4;
		for (int i = 0; i < 3; i++) begin
			rnd            = acc_s4[i] + (53'sd1 <<< (COEF_FRAC_BITS - 1));
			sh             = rnd >>> COEF_FRAC_BITS;
			st             = sat32(64'(sh));
			side_c.pos[i]  = st.val;
			side_c.clip    = side_c.clip | st.clip;
		end
		// a negative bone means a static vertex
		side_c.joint  = bone_q[16] ? 16'd0 : bone_q[15:0];
		side_c.weight = !bone_q[16];
		side_c.neg    = neg_s4;
		side_c.zero   = (max_s4 == '0);

		// bring the largest magnitude into [2^30, 2^31)
		msb_c = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (max_s4[b]) begin
				msb_c = 6'(b);
			end
		end
		if (msb_c >= 6'(A_W - 1)) begin
			rsh_c = 3'(msb_c - 6'(A_W - 1));
			lsh_c = '0;
		end else begin
			rsh_c = '0;
			lsh_c = 5'(6'(A_W - 1) - msb_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_c;
			mag_s5  <= mag_s4;
			rsh_s5  <= rsh_c;
			lsh_s5  <= lsh_c;
		end
	end

	// ---------------- stage 6: apply shift (right shift truncates) ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_c[i] = A_W'((mag_s5[i] >> rsh_s5) << lsh_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s6    <= a_c;
			side_s6 <= side_s5;
		end
	end

	// ---------------- stage 7: squares ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= a_s6[i] * a_s6[i];
			end
			a_s7    <= a_s6;
			side_s7 <= side_s6;
		end
	end

	// ---------------- stage 8: squared length feeds the root pipe ----------------
	always_comb begin
		isq_head_c.sq.rem  = 64'(sq_s7[0]) + 64'(sq_s7[1]) + 64'(sq_s7[2]);
		isq_head_c.sq.root = '0;
		isq_head_c.a       = a_s7;
		isq_head_c.side    = side_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			isq_s[0] <= isq_head_c;
		end
	end

	// ---------------- integer square root, ISQ_STEPS steps per stage ----------------
	for (genvar k = 1; k <= ISQ_STAGES; k++) begin : g_isq
		isq_t nxt;
		always_comb begin
			nxt = isq_s[k-1];
			for (int j = 0; j < ISQ_STEPS; j++) begin
				nxt.sq = isq_step(nxt.sq, (k - 1) * ISQ_STEPS + j);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				isq_s[k] <= nxt;
			end
		end
	end

	// ---------------- divide setup: numerator with half-length rounding ----------------
	always_comb begin
		dv_head_c.len  = isq_s[ISQ_STAGES].sq.root[31:0];
		dv_head_c.side = isq_s[ISQ_STAGES].side;
		for (int i = 0; i < 3; i++) begin
			dv_head_c.rem[i] = REM_W'({isq_s[ISQ_STAGES].a[i], NORM_ONE_BITS'(0)})
				+ REM_W'(dv_head_c.len >> 1);
			dv_head_c.q[i]   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= dv_head_c;
		end
	end

	// ---------------- restoring divide, DIV_STEPS quotient bits per stage ----------------
	for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
		div_t nxt;
		always_comb begin
			logic [REM_W-1:0] cmp;
			nxt = dv_s[j-1];
			for (int t = 0; t < DIV_STEPS; t++) begin
				for (int i = 0; i < 3; i++) begin
					cmp = REM_W'(nxt.len) << (DIV_BITS - 1 - (j - 1) * DIV_STEPS - t);
					if (nxt.rem[i] >= cmp) begin
						nxt.rem[i] = nxt.rem[i] - cmp;
						nxt.q[i][DIV_BITS - 1 - (j - 1) * DIV_STEPS - t] = 1'b1;
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j] <= nxt;
			end
		end
	end

	// ---------------- output register ----------------
	always_comb begin
		logic [15:0] nq;
		out_c = '0;
		for (int i = 0; i < 3; i++) begin
			out_c[32*i +: 32] = dv_s[DIV_STAGES].side.pos[i];
			nq = 16'(dv_s[DIV_STAGES].q[i]);
			// zero-length normal passes through as zero
			if (dv_s[DIV_STAGES].side.zero) begin
				out_c[96 + 16*i +: 16] = '0;
			end else if (dv_s[DIV_STAGES].side.neg[i]) begin
				out_c[96 + 16*i +: 16] = -nq;
			end else begin
				out_c[96 + 16*i +: 16] = nq;
			end
		end
		out_c[159:144] = dv_s[DIV_STAGES].side.joint;
		out_c[160]     = dv_s[DIV_STAGES].side.weight;
		out_c[161]     = dv_s[DIV_STAGES].side.clip;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q <= out_c;
		end
	end

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the vertex transform core with normal renormalization.
`timescale 1ns / 1ps
module tb_top;
	import vatr_pkg::*;

	// Latency allowance after the last result, and watchdog limit on idle cycles.
	localparam int DRAIN_CYCLES = 64;
	localparam int STALL_LIMIT  = 5000;

	typedef struct packed {
		logic signed [2:0][15:0] nrm;
		logic signed [2:0][31:0] pos;
	} vertex_t;

	typedef struct {
		logic [31:0] pos [3];
		logic [15:0] nrm [3];
		logic [15:0] joint;
		logic        weight;
		logic        clip;
	} xform_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [5:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;

	// Shadow copy of the configuration registers.
	logic [ROW_W-1:0] row_q [3];
	logic [31:0]      off_q [3];
	logic [31:0]      scale_q;
	logic [16:0]      bone_q;

	xform_t expected_q [$];
	int     mismatch_cnt;
	int     vertex_cnt;
	int     result_cnt;
	int     clip_cnt;
	int     send_idle_pct;
	int     recv_idle_pct;
	int     idle_cycles;

	vertex_affine_transform_renorm_core i_dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v,
			input int sh);
		return v >>> sh;
	endfunction

	function automatic logic signed [63:0] sat_clip(input logic signed [63:0] v,
			inout logic clip);
		if (v > 64'sd2147483647) begin
			clip = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clip = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - res - b;
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] coef_of(input int row, input int k);
		logic signed [COEF_W-1:0] c;
		c = row_q[row][k*COEF_W +: COEF_W];
		return 64'(c);
	endfunction

	// Compute the transformed vertex for the current register settings.
	function automatic xform_t transform_vertex(input vertex_t v);
		xform_t           o;
		logic             clip;
		logic signed [63:0] s [3];
		logic signed [63:0] n [3];
		logic signed [63:0] r [3];
		logic [63:0]      mag [3];
		logic [63:0]      mx;
		logic [63:0]      len;
		logic [63:0]      q;
		logic signed [63:0] acc;
		logic signed [63:0] nr;
		clip = 1'b0;
		mx   = 0;
		for (int i = 0; i < 3; i++) begin
			// element selects of a packed array are unsigned: sign-extend explicitly
			acc  = 64'($signed(v.pos[i])) * $signed({32'd0, scale_q});
			s[i] = sat_clip(floor_shift(acc + (64'sd1 <<< (POS_FRAC_BITS - 1)),
					POS_FRAC_BITS), clip);
			n[i] = 64'($signed(v.nrm[i]));
		end
		for (int i = 0; i < 3; i++) begin
			acc = 64'($signed(off_q[i])) <<< COEF_FRAC_BITS;
			nr  = 0;
			for (int k = 0; k < 3; k++) begin
				acc += coef_of(i, k) * s[k];
				nr  += coef_of(i, k) * n[k];
			end
			o.pos[i] = 32'(sat_clip(floor_shift(acc + (64'sd1 <<< (COEF_FRAC_BITS - 1)),
					COEF_FRAC_BITS), clip));
			r[i]   = nr;
			mag[i] = nr < 0 ? 64'(-nr) : 64'(nr);
			if (mag[i] > mx)
				mx = mag[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 3; i++)
				o.nrm[i] = '0;
		end else begin
			// bring the largest magnitude into [2^30, 2^31), truncating on the way down
			while (mx >= 64'd1 << 31) begin
				mx = mx >> 1;
				for (int i = 0; i < 3; i++)
					mag[i] = mag[i] >> 1;
			end
			while (mx < 64'd1 << 30) begin
				mx = mx << 1;
				for (int i = 0; i < 3; i++)
					mag[i] = mag[i] << 1;
			end
			len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
			for (int i = 0; i < 3; i++) begin
				q = ((mag[i] << NORM_ONE_BITS) + (len >> 1)) / len;
				o.nrm[i] = r[i] < 0 ? 16'(-q) : 16'(q);
			end
		end
		if (bone_q[16]) begin
			o.joint  = '0;
			o.weight = 1'b0;
		end else begin
			o.joint  = bone_q[15:0];
			o.weight = 1'b1;
		end
		o.clip = clip;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH result %0d %s: got %h expected %h", result_cnt, what, got, want);
		mismatch_cnt++;
	endtask

	// Write one register through the APB port: setup cycle, then access cycle.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ROW_X, REG_ROW_Y, REG_ROW_Z: row_q[idx] = value[ROW_W-1:0];
			REG_OFF_X, REG_OFF_Y, REG_OFF_Z: off_q[idx - REG_OFF_X] = value[31:0];
			REG_SCALE: scale_q = value[31:0];
			default: bone_q = value[16:0];
		endcase
	endtask

	// Send one vertex request, idling first at the current sender rate.
	task automatic send_vertex(input vertex_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		expected_q.insert(expected_q.size(), transform_vertex(v));
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		vertex_cnt++;
	endtask

	// Hold off until every expected result has come back and the pipe is empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	function automatic vertex_t random_vertex();
		vertex_t v;
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(3))
				0: v.pos[i] = $urandom;
				1: v.pos[i] = $signed($urandom_range(2000000)) - 1000000;
				2: v.pos[i] = $signed($urandom_range(65536 * 40)) - 65536 * 20;
				default: v.pos[i] = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			endcase
			v.nrm[i] = $urandom_range(3) == 0 ? 16'($urandom)
					: 16'($signed($urandom_range(32768)) - 16384);
		end
		return v;
	endfunction

	function automatic logic [63:0] random_row();
		logic [ROW_W-1:0] r;
		for (int k = 0; k < 3; k++)
			r[k*COEF_W +: COEF_W] = $urandom_range(3) == 0 ? 18'($urandom)
					: 18'($signed($urandom_range(65536)) - 32768);
		return 64'(r);
	endfunction

	task automatic load_random_config();
		write_reg(REG_ROW_X, random_row());
		write_reg(REG_ROW_Y, random_row());
		write_reg(REG_ROW_Z, random_row());
		write_reg(REG_OFF_X, 64'($urandom));
		write_reg(REG_OFF_Y, 64'($signed($urandom_range(200000)) - 100000));
		write_reg(REG_OFF_Z, 64'($urandom));
		write_reg(REG_SCALE, $urandom_range(1) ? 64'($urandom_range(1, 200000))
				: 64'($urandom));
		write_reg(REG_BONE, $urandom_range(2) == 0 ? 64'h1_ffff : 64'($urandom_range(17'h1ffff)));
	endtask

	// Field extremes, zero normal, zero scale, saturation and both bindings.
	task automatic test_directed();
		vertex_t v;
		v = '0;
		send_vertex(v);
		v.pos = {32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
		v.nrm = {16'h7fff, 16'h8000, 16'h0001};
		send_vertex(v);
		v.pos = {32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
		v.nrm = {16'hffff, 16'h0000, 16'h0000};
		send_vertex(v);
		drain();
		write_reg(REG_ROW_X, 64'h3_ffff_ffff_ffff);
		write_reg(REG_ROW_Y, {10'd0, 18'h20000, 18'h1ffff, 18'h20000});
		write_reg(REG_ROW_Z, 64'h0);
		write_reg(REG_OFF_X, 64'h7fff_ffff);
		write_reg(REG_OFF_Y, 64'h8000_0000);
		write_reg(REG_OFF_Z, 64'h0);
		write_reg(REG_SCALE, 64'hffff_ffff);
		write_reg(REG_BONE, 64'h0_ffff);
		v.pos = {32'h0000_8000, 32'hffff_8000, 32'h7fff_ffff};
		v.nrm = {16'h7fff, 16'h7fff, 16'h7fff};
		send_vertex(v);
		v.pos = {32'h0000_0001, 32'hffff_ffff, 32'h0000_0000};
		v.nrm = {16'h8000, 16'h8000, 16'h8000};
		send_vertex(v);
		drain();
		write_reg(REG_SCALE, 64'h0);
		write_reg(REG_BONE, 64'h1_0000);
		write_reg(REG_ROW_Z, 64'h1);
		v.pos = {32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff};
		v.nrm = {16'h0000, 16'h0000, 16'h0001};
		send_vertex(v);
		v.nrm = {16'h0000, 16'h0000, 16'h0000};
		send_vertex(v);
		drain();
		write_reg(REG_SCALE, 64'h1);
		write_reg(REG_BONE, 64'h0);
		for (int i = 0; i < 6; i++)
			send_vertex(random_vertex());
		drain();
	endtask

	// Random vertices under a few register settings at the given idle rates.
	task automatic test_random(input int send_pct, input int recv_pct, input int count);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int phase = 0; phase < 4; phase++) begin
			load_random_config();
			for (int n = 0; n < count / 4; n++) begin
				// once per phase, halfway through, hold until all results are back
				if (n == count / 8)
					drain();
				send_vertex(random_vertex());
			end
			drain();
		end
	endtask

	// Receive side: stall at random, check each result against the oldest expectation.
	always @(posedge clk) begin
		xform_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", 64'(m_tdata), 0);
				end else begin
					e = expected_q.pop_front();
					for (int i = 0; i < 3; i++) begin
						if (m_tdata[32*i +: 32] !== e.pos[i])
							report_mismatch($sformatf("out_pos[%0d]", i),
									m_tdata[32*i +: 32], e.pos[i]);
						if (m_tdata[96 + 16*i +: 16] !== e.nrm[i])
							report_mismatch($sformatf("out_norm[%0d]", i),
									m_tdata[96 + 16*i +: 16], e.nrm[i]);
					end
					if (m_tdata[159:144] !== e.joint)
						report_mismatch("joint_index", m_tdata[159:144], e.joint);
					if (m_tdata[160] !== e.weight)
						report_mismatch("weight_full", m_tdata[160], e.weight);
					if (m_tdata[161] !== e.clip)
						report_mismatch("clipped", m_tdata[161], e.clip);
					if (e.clip)
						clip_cnt++;
				end
				result_cnt++;
			end
			m_tready <= $urandom_range(99) >= recv_idle_pct;
			// advance the watchdog only while nothing moves
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
				$display("vertex_affine_transform_renorm_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		m_tready      = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		mismatch_cnt  = 0;
		vertex_cnt    = 0;
		result_cnt    = 0;
		clip_cnt      = 0;
		idle_cycles   = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		row_q[0] = 54'd16384;
		row_q[1] = 54'd16384 << 18;
		row_q[2] = 54'd16384 << 36;
		off_q    = '{default: '0};
		scale_q  = 32'd65536;
		bone_q   = 17'h1ffff;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(32, 48, 680);
		test_random(48, 32, 680);
		test_random(0, 0, 680);
		drain();
		$display("covered %0d vertices, %0d results (%0d clipped) over directed and random",
				vertex_cnt, result_cnt, clip_cnt);
		$display("register settings with three sender/receiver idle mixes");
		if (mismatch_cnt == 0 && expected_q.size() == 0) begin
			$display("vertex_affine_transform_renorm_core regression: pass");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatch_cnt,
					expected_q.size());
			$display("vertex_affine_transform_renorm_core regression: fail");
		end
		$finish;
	end

endmodule
